// ===== hw/rtl/vpsd_pkg.sv =====
package vpsd_pkg;

  localparam int PACKET_BYTES        = 164;
  localparam int HEADER_BYTES        = 4;
  localparam int PAYLOAD_BYTES       = PACKET_BYTES - HEADER_BYTES;
  localparam int PACKETS_PER_SEGMENT = 60;
  localparam int SEGMENTS_PER_FRAME  = 4;
  localparam int SEGMENT_ID_PACKET   = 20;

  localparam logic [11:0] PACKET_NUM_MASK = 12'h0FFF;
  localparam logic [2:0]  SEGMENT_ID_MASK = 3'h7;
  localparam logic [3:0]  DISCARD_NIBBLE  = 4'hF;
  localparam logic [3:0]  RETRY_MAX       = 4'hF;
  localparam logic [3:0]  RETRY_RESET     = 4'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD      = 2'd0,
    KIND_FRAME_DONE   = 2'd1,
    KIND_RESYNC       = 2'd2,
    KIND_CAPTURE_FAIL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SKIP_NONE    = 2'd0,
    SKIP_DISCARD = 2'd1,
    SKIP_BAD     = 2'd2
  } skip_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic [31:0] frames_completed;
    logic [3:0]  retries_used;
    logic        last_of_run;
  } result_t;

  // up to two results per item, second only with the first
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } res_pair_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room;
  } queue_status_t;

endpackage

// ===== hw/rtl/video_packet_segment_deframer.sv =====
// Packet-segment video deframer.
// Slave stream: one item per received link byte (s_tdata) or, with s_tuser
// high, a command to start a new frame capture. Master stream: payload
// writes for the frame buffer, frame-complete, resync-request and
// capture-failed reports, one report per transfer; m_tlast marks the last report
// caused by one input item (an item causes zero, one or two).
// Config channel: cfg_data sets the retry limit; it is always ready and
// should only be written while nothing is in flight.
// Path: an item is captured in the input register, processed combinationally
// by the core and written into a four-entry result queue, whose head drives
// m_tvalid and m_tdata.
// Throughput is one item per cycle while the queue has room; an item with two
// reports needs an extra output transfer, absorbed by the queue.
// Receiver stall: the queue fills, the processing stage holds its item
// once fewer than two entries are free, and s_tready drops.
// Reset: capture idle (bytes ignored until a start command), counters
// zero, retry limit 5, queue empty.
module video_packet_segment_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] write_address, [23:16] write_byte,
                                 // [55:24] frames_completed, [59:56] retries_used
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data   // retry limit
);

  logic                    in_valid;
  logic                    in_opcode;
  logic [7:0]              in_byte;
  logic                    fire;
  logic [3:0]              retry_limit;
  vpsd_pkg::res_pair_t     res;
  vpsd_pkg::result_t       head;
  vpsd_pkg::queue_status_t qstat;

  assign fire      = in_valid && qstat.room;
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      retry_limit <= vpsd_pkg::RETRY_RESET;
    end else begin
      if (s_tready)
        in_valid <= s_tvalid;
      if (cfg_valid)
        retry_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  vpsd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .retry_limit (retry_limit),
    .fire        (fire),
    .opcode      (in_opcode),
    .rx_byte     (in_byte),
    .res         (res)
  );

  vpsd_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .pop    (m_tready),
    .head   (head),
    .status (qstat)
  );

  assign m_tvalid = qstat.count != '0;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last_of_run;
  assign m_tdata  = {4'b0, head.retries_used, head.frames_completed,
                     head.write_byte, head.write_address};

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= vpsd_pkg::QCNT_W'(vpsd_pkg::QUEUE_DEPTH))
    else $error("result queue overrun");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    res.v1 |-> (res.v0 && fire))
    else $error("second result without first");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == vpsd_pkg::KIND_CAPTURE_FAIL) |-> m_tlast)
    else $error("capture-failed report not last of its run");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !qstat.room) |=> in_valid && $stable(in_byte) && $stable(in_opcode))
    else $error("held item lost while queue full");
`endif

endmodule

// ===== hw/rtl/vpsd_core.sv =====
module vpsd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          retry_limit,
  input  logic                fire,
  input  logic                opcode,
  input  logic [7:0]          rx_byte,
  output vpsd_pkg::res_pair_t res
);

  logic                active, active_next;
  logic [7:0]          byte_pos, byte_pos_next;
  logic [5:0]          packet_pos, packet_pos_next;
  logic [2:0]          segs_done, segs_done_next;
  logic [3:0]          retry_count, retry_count_next;
  logic [7:0]          id_high, id_high_next;
  vpsd_pkg::skip_t     skip, skip_next;
  logic [31:0]         frame_counter, frame_counter_next;

  always_comb begin
    vpsd_pkg::skip_t skip_v;
    logic [15:0]     id_v;
    logic [8:0]      row_v;
    logic [15:0]     addr_v;
    logic [6:0]      pp_inc;
    logic [3:0]      sd_inc;
    logic [3:0]      rc_v;

    active_next        = active;
    byte_pos_next      = byte_pos;
    packet_pos_next    = packet_pos;
    segs_done_next     = segs_done;
    retry_count_next   = retry_count;
    id_high_next       = id_high;
    skip_next          = skip;
    frame_counter_next = frame_counter;
    res                = '0;

    skip_v = skip;
    id_v   = {id_high, rx_byte};
    row_v  = 9'(segs_done * 9'(vpsd_pkg::PACKETS_PER_SEGMENT)) + 9'(packet_pos);
    addr_v = 16'(row_v * 16'(vpsd_pkg::PAYLOAD_BYTES))
           + 16'(byte_pos - 8'(vpsd_pkg::HEADER_BYTES));
    pp_inc = {1'b0, packet_pos} + 7'd1;
    sd_inc = {1'b0, segs_done} + 4'd1;
    rc_v   = (retry_count < vpsd_pkg::RETRY_MAX) ? retry_count + 4'd1 : retry_count;

    if (fire) begin
      if (opcode == vpsd_pkg::OP_START) begin
        active_next      = 1'b1;
        byte_pos_next    = '0;
        packet_pos_next  = '0;
        segs_done_next   = '0;
        retry_count_next = '0;
        id_high_next     = '0;
        skip_next        = vpsd_pkg::SKIP_NONE;
        if (retry_limit == 4'd0) begin
          active_next             = 1'b0;
          res.v0                  = 1'b1;
          res.r0.kind             = vpsd_pkg::KIND_CAPTURE_FAIL;
          res.r0.frames_completed = frame_counter;
        end
      end else if (active) begin
        if (byte_pos == 8'd0) begin
          id_high_next = rx_byte;
          skip_v       = vpsd_pkg::SKIP_NONE;
          if (rx_byte[3:0] == vpsd_pkg::DISCARD_NIBBLE)
            skip_v = (packet_pos == 6'd0) ? vpsd_pkg::SKIP_DISCARD : vpsd_pkg::SKIP_BAD;
        end else if (byte_pos == 8'd1 && skip == vpsd_pkg::SKIP_NONE) begin
          if ((id_v[11:0] & vpsd_pkg::PACKET_NUM_MASK) != 12'(packet_pos))
            skip_v = vpsd_pkg::SKIP_BAD;
          else if (packet_pos == 6'(vpsd_pkg::SEGMENT_ID_PACKET) &&
                   {1'b0, id_v[14:12] & vpsd_pkg::SEGMENT_ID_MASK} != sd_inc)
            skip_v = vpsd_pkg::SKIP_BAD;
        end

        if (skip_v == vpsd_pkg::SKIP_NONE && byte_pos >= 8'(vpsd_pkg::HEADER_BYTES)) begin
          res.v0                  = 1'b1;
          res.r0.kind             = vpsd_pkg::KIND_PAYLOAD;
          res.r0.write_address    = addr_v;
          res.r0.write_byte       = rx_byte;
          res.r0.frames_completed = frame_counter;
          res.r0.retries_used     = retry_count;
        end

        if (byte_pos == 8'(vpsd_pkg::PACKET_BYTES - 1)) begin
          byte_pos_next = '0;
          skip_next     = vpsd_pkg::SKIP_NONE;
          if (skip_v == vpsd_pkg::SKIP_NONE) begin
            packet_pos_next = pp_inc[5:0];
            if (pp_inc >= 7'(vpsd_pkg::PACKETS_PER_SEGMENT)) begin
              packet_pos_next  = '0;
              segs_done_next   = sd_inc[2:0];
              retry_count_next = '0;
              if (sd_inc >= 4'(vpsd_pkg::SEGMENTS_PER_FRAME)) begin
                // last payload byte sits in r0, so frame done goes second
                frame_counter_next      = frame_counter + 32'd1;
                active_next             = 1'b0;
                res.v1                  = 1'b1;
                res.r1.kind             = vpsd_pkg::KIND_FRAME_DONE;
                res.r1.frames_completed = frame_counter + 32'd1;
              end
            end
          end else if (skip_v == vpsd_pkg::SKIP_BAD) begin
            segs_done_next          = '0;
            packet_pos_next         = '0;
            retry_count_next        = rc_v;
            res.v0                  = 1'b1;
            res.r0.kind             = vpsd_pkg::KIND_RESYNC;
            res.r0.frames_completed = frame_counter;
            res.r0.retries_used     = rc_v;
            if (rc_v >= retry_limit) begin
              active_next             = 1'b0;
              res.v1                  = 1'b1;
              res.r1.kind             = vpsd_pkg::KIND_CAPTURE_FAIL;
              res.r1.frames_completed = frame_counter;
              res.r1.retries_used     = rc_v;
            end
          end
        end else begin
          byte_pos_next = byte_pos + 8'd1;
          skip_next     = skip_v;
        end
      end
    end

    res.r0.last_of_run = res.v0 & ~res.v1;
    res.r1.last_of_run = res.v1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      byte_pos      <= '0;
      packet_pos    <= '0;
      segs_done     <= '0;
      retry_count   <= '0;
      id_high       <= '0;
      skip          <= vpsd_pkg::SKIP_NONE;
      frame_counter <= '0;
    end else begin
      active        <= active_next;
      byte_pos      <= byte_pos_next;
      packet_pos    <= packet_pos_next;
      segs_done     <= segs_done_next;
      retry_count   <= retry_count_next;
      id_high       <= id_high_next;
      skip          <= skip_next;
      frame_counter <= frame_counter_next;
    end
  end

endmodule

// ===== hw/rtl/vpsd_result_queue.sv =====
module vpsd_result_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  vpsd_pkg::res_pair_t     res,
  input  logic                    pop,
  output vpsd_pkg::result_t       head,
  output vpsd_pkg::queue_status_t status
);

  vpsd_pkg::result_t                 entries [vpsd_pkg::QUEUE_DEPTH];
  logic [vpsd_pkg::QPTR_W-1:0]       wr_ptr, wr_ptr_next;
  logic [vpsd_pkg::QPTR_W-1:0]       rd_ptr, rd_ptr_next;
  logic [vpsd_pkg::QCNT_W-1:0]       count, count_next;
  logic [vpsd_pkg::QCNT_W-1:0]       push_n;
  logic                              do_pop;

  assign do_pop = pop && (count != '0);
  assign push_n = vpsd_pkg::QCNT_W'(res.v0) + vpsd_pkg::QCNT_W'(res.v1);

  always_comb begin
    wr_ptr_next = wr_ptr + vpsd_pkg::QPTR_W'(push_n);
    rd_ptr_next = rd_ptr + vpsd_pkg::QPTR_W'(do_pop);
    count_next  = count + push_n - vpsd_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (res.v0)
      entries[wr_ptr] <= res.r0;
    if (res.v1)
      entries[wr_ptr + vpsd_pkg::QPTR_W'(1)] <= res.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  // room for a full pair whatever the reader does this cycle
  assign status.room  = count <= vpsd_pkg::QCNT_W'(vpsd_pkg::QUEUE_DEPTH - 2);

endmodule

// ===== dv/video_packet_segment_deframer_tb.sv =====
`timescale 1ns / 1ps

module video_packet_segment_deframer_tb;
  import vpsd_pkg::*;

  localparam int TOTAL_ITEMS     = 1550;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_PACKET
  } row_kind_t;

  typedef struct {
    row_kind_t   what;
    op_t         op;
    logic [15:0] val;    // byte, limit or packet id word
    int          len;    // bytes of the packet actually sent
    int          n_exp;  // -1: predicted, else number of typed reports
    result_t     exp;
  } stim_row_t;

  localparam result_t NO_REPORT = '0;
  localparam result_t ZERO_LIMIT_FAIL = '{KIND_CAPTURE_FAIL, 16'h0, 8'h0, 32'h0, 4'h0, 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  video_packet_segment_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // deframer state as the testbench sees it
  logic [3:0]  fail_limit = RETRY_RESET;
  logic        cap_active = 1'b0;
  int          byte_pos   = 0;
  int          pkt_pos    = 0;
  int          seg_done   = 0;
  logic [3:0]  retries    = '0;
  logic [7:0]  id_hi      = '0;
  skip_t       skip_state = SKIP_NONE;
  logic [31:0] done_frames = '0;

  result_t     step_res [2];
  int          step_n;
  result_t     due_reports [$];

  int          errors      = 0;
  int          sent_items  = 0;
  int          quiet       = 0;
  int          stall_left  = 0;
  logic        idle_on     = 1'b1;

  stim_row_t dir_rows [21] = '{
    '{ROW_ITEM,   OP_BYTE,  16'h0000, 0,   0, NO_REPORT},       // idle, ignored
    '{ROW_ITEM,   OP_BYTE,  16'h00FF, 0,   0, NO_REPORT},
    '{ROW_CFG,    OP_BYTE,  16'h0000, 0,  -1, NO_REPORT},
    '{ROW_ITEM,   OP_START, 16'h0000, 0,   1, ZERO_LIMIT_FAIL},
    '{ROW_ITEM,   OP_BYTE,  16'h005A, 0,   0, NO_REPORT},
    '{ROW_CFG,    OP_BYTE,  16'h0002, 0,  -1, NO_REPORT},
    '{ROW_ITEM,   OP_START, 16'h0000, 0,   0, NO_REPORT},
    '{ROW_PACKET, OP_BYTE,  16'hFFFF, PACKET_BYTES, -1, NO_REPORT}, // discard, segment start
    '{ROW_PACKET, OP_BYTE,  16'h0000, PACKET_BYTES, -1, NO_REPORT},
    '{ROW_PACKET, OP_BYTE,  16'h8001, PACKET_BYTES, -1, NO_REPORT},
    '{ROW_PACKET, OP_BYTE,  16'h0F02, PACKET_BYTES, -1, NO_REPORT}, // discard mid-segment
    '{ROW_PACKET, OP_BYTE,  16'h0100, PACKET_BYTES, -1, NO_REPORT}, // wrong number, limit hit
    '{ROW_ITEM,   OP_BYTE,  16'h00FF, 0,   0, NO_REPORT},
    '{ROW_CFG,    OP_BYTE,  16'h000F, 0,  -1, NO_REPORT},
    '{ROW_ITEM,   OP_START, 16'h0000, 0,   0, NO_REPORT},
    '{ROW_PACKET, OP_BYTE,  16'h7000, PACKET_BYTES, -1, NO_REPORT},
    '{ROW_PACKET, OP_BYTE,  16'h0001, 37, -1, NO_REPORT},
    '{ROW_ITEM,   OP_START, 16'h0000, 0,  -1, NO_REPORT},       // restart while active
    '{ROW_PACKET, OP_BYTE,  16'h0FFF, PACKET_BYTES, -1, NO_REPORT},
    '{ROW_PACKET, OP_BYTE,  16'h0000, 3,  -1, NO_REPORT},
    '{ROW_ITEM,   OP_START, 16'h0000, 0,  -1, NO_REPORT}
  };

  function automatic void push_report(kind_t k, logic [15:0] addr, logic [7:0] data);
    step_res[step_n] = '{k, addr, data, done_frames, retries, 1'b0};
    step_n++;
  endfunction

  function automatic void deframe_step(op_t op, logic [7:0] b);
    int row;
    step_n = 0;
    if (op == OP_START) begin
      cap_active = 1'b1;
      byte_pos   = 0;
      pkt_pos    = 0;
      seg_done   = 0;
      retries    = '0;
      id_hi      = '0;
      skip_state = SKIP_NONE;
      if (retries >= fail_limit) begin
        cap_active = 1'b0;
        push_report(KIND_CAPTURE_FAIL, '0, '0);
      end
    end else if (cap_active) begin
      if (byte_pos == 0) begin
        id_hi      = b;
        skip_state = SKIP_NONE;
        if (b[3:0] == DISCARD_NIBBLE)
          skip_state = (pkt_pos == 0) ? SKIP_DISCARD : SKIP_BAD;
      end else if (byte_pos == 1 && skip_state == SKIP_NONE) begin
        if ({id_hi[3:0], b} != 12'(pkt_pos))
          skip_state = SKIP_BAD;
        else if (pkt_pos == SEGMENT_ID_PACKET && id_hi[6:4] != 3'(seg_done + 1))
          skip_state = SKIP_BAD;
      end

      if (skip_state == SKIP_NONE && byte_pos >= HEADER_BYTES) begin
        row = seg_done * PACKETS_PER_SEGMENT + pkt_pos;
        push_report(KIND_PAYLOAD, 16'(row * PAYLOAD_BYTES + byte_pos - HEADER_BYTES), b);
      end

      if (byte_pos + 1 >= PACKET_BYTES) begin
        byte_pos = 0;
        if (skip_state == SKIP_NONE) begin
          pkt_pos++;
          if (pkt_pos >= PACKETS_PER_SEGMENT) begin
            pkt_pos = 0;
            seg_done++;
            retries = '0;
            if (seg_done >= SEGMENTS_PER_FRAME) begin
              done_frames++;
              cap_active = 1'b0;
              push_report(KIND_FRAME_DONE, '0, '0);
            end
          end
        end else if (skip_state == SKIP_BAD) begin
          seg_done = 0;
          pkt_pos  = 0;
          if (retries < RETRY_MAX)
            retries++;
          push_report(KIND_RESYNC, '0, '0);
          if (retries >= fail_limit) begin
            cap_active = 1'b0;
            push_report(KIND_CAPTURE_FAIL, '0, '0);
          end
        end
        skip_state = SKIP_NONE;
      end else begin
        byte_pos++;
      end
    end
    if (step_n > 0)
      step_res[step_n-1].last_of_run = 1'b1;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70)
      return 0;
    if (r < 94)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return 8'h00;
    if (r < 20)
      return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] good_id();
    logic [2:0] seg_id;
    seg_id = 3'($urandom_range(0, 7));
    if (pkt_pos == SEGMENT_ID_PACKET)
      seg_id = 3'(seg_done + 1);
    return {1'($urandom_range(0, 1)), seg_id, 12'(pkt_pos)};
  endfunction

  // packet number off by one bit; low nibble of the high byte cannot become the discard code
  function automatic logic [15:0] misnumbered_id();
    logic [11:0] num;
    num = 12'(pkt_pos) ^ (12'd1 << $urandom_range(0, 11));
    return {4'($urandom_range(0, 15)), num};
  endfunction

  function automatic logic [15:0] discard_id();
    return {4'($urandom_range(0, 15)), DISCARD_NIBBLE, 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [15:0] wrong_segment_id();
    logic [2:0] seg_id;
    seg_id = 3'(seg_done + 1 + $urandom_range(1, 7));
    return {1'($urandom_range(0, 1)), seg_id, 12'(pkt_pos)};
  endfunction

  function automatic logic [3:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return 4'd0;
    if (r < 22)
      return 4'd15;
    if (r < 75)
      return 4'($urandom_range(1, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t  mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(op_t op, logic [7:0] b, int n_typed, result_t typed);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
    deframe_step(op, b);
    if (n_typed < 0) begin
      for (int j = 0; j < step_n; j++)
        due_reports.push_back(step_res[j]);
    end else if (n_typed > 0) begin
      due_reports.push_back(typed);
    end
    @(negedge clk);
  endtask

  task automatic send_packet(logic [15:0] id, int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0)
        b = id[15:8];
      else if (i == 1)
        b = id[7:0];
      else
        b = rand_byte();
      send_item(OP_BYTE, b, -1, NO_REPORT);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fail_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready   <= 1'b1;
      stall_left <= draw_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (due_reports.size() == 0) begin
          note_mismatch("unexpected report, kind", m_tuser, '0);
        end else begin
          want = due_reports.pop_front();
          if (m_tuser != want.kind)
            note_mismatch("kind", m_tuser, want.kind);
          if (m_tdata[15:0] != want.write_address)
            note_mismatch("write_address", m_tdata[15:0], want.write_address);
          if (m_tdata[23:16] != want.write_byte)
            note_mismatch("write_byte", m_tdata[23:16], want.write_byte);
          if (m_tdata[55:24] != want.frames_completed)
            note_mismatch("frames_completed", m_tdata[55:24], want.frames_completed);
          if (m_tdata[59:56] != want.retries_used)
            note_mismatch("retries_used", m_tdata[59:56], want.retries_used);
          if (m_tlast != want.last_of_run)
            note_mismatch("last_of_run", m_tlast, want.last_of_run);
        end
      end
    end
  end

  initial begin
    int sel;
    int r;
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].what)
        ROW_CFG: begin
          wait_drain();
          write_limit(dir_rows[i].val[3:0]);
        end
        ROW_ITEM: begin
          send_item(dir_rows[i].op, dir_rows[i].val[7:0], dir_rows[i].n_exp, dir_rows[i].exp);
        end
        default: begin
          send_packet(dir_rows[i].val, dir_rows[i].len);
        end
      endcase
    end

    while (sent_items < TOTAL_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        wait_drain();
        write_limit(pick_limit());
      end else if (sel < 45) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0)
            send_item(OP_START, rand_byte(), -1, NO_REPORT);
          else
            send_item(OP_BYTE, rand_byte(), -1, NO_REPORT);
        end
      end else if (sel < 60) begin
        send_packet(good_id(), $urandom_range(1, PACKET_BYTES - 1));
        send_item(OP_START, rand_byte(), -1, NO_REPORT);
      end else begin
        if (!cap_active || byte_pos != 0)
          send_item(OP_START, rand_byte(), -1, NO_REPORT);
        if (cap_active) begin
          r = $urandom_range(0, 99);
          if (r < 55)
            send_packet(good_id(), PACKET_BYTES);
          else if (r < 65)
            send_packet(discard_id(), PACKET_BYTES);
          else if (r < 85)
            send_packet(misnumbered_id(), PACKET_BYTES);
          else if (r < 92 && pkt_pos == SEGMENT_ID_PACKET)
            send_packet(wrong_segment_id(), PACKET_BYTES);
          else
            send_packet(16'($urandom_range(0, 65535)), PACKET_BYTES);
        end
      end
      if ($urandom_range(0, 9) == 0)
        idle_on = !idle_on;
    end

    wait_drain();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vpsd_pkg.sv
hw/rtl/vpsd_core.sv
hw/rtl/vpsd_result_queue.sv
hw/rtl/video_packet_segment_deframer.sv
dv/video_packet_segment_deframer_tb.sv
